[design/sorted_list_insert_delete_assert.svh]
// ----------------------------------------------------------------------------
// sorted list assertion macros
// shared forms for the concurrent checks of the sorted list store
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SLID_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sorted list check failed");

// next-cycle implication, disabled while reset is asserted
`define SLID_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sorted list check failed");

`endif

[design/slid_pkg.sv]
// ----------------------------------------------------------------------------
// slid_pkg
// types, codes and constants shared by the sorted list store and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package slid_pkg;

    localparam int CAPACITY = 32;
    localparam int VAL_W    = 32;
    localparam int FILL_W   = 6;

    typedef logic [FILL_W-1:0] t_fill;

    // request kinds
    localparam logic [1:0] KIND_INSERT    = 2'd0;
    localparam logic [1:0] KIND_DELETE    = 2'd1;
    localparam logic [1:0] KIND_READ_ASC  = 2'd2;
    localparam logic [1:0] KIND_READ_DESC = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] value_out;
        logic                    last;
        logic [FILL_W-1:0]       fill;
    } t_out_beat;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_INS  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_ROTL = 3'd3,
        CELL_ROTR = 3'd4
    } t_cell_op;

    // where a cell sits relative to the current fill
    typedef struct packed {
        logic occ;       // index below fill
        logic at_tail;   // index equals fill - 1
        logic at_count;  // index equals fill
    } t_cell_pos;

endpackage

`default_nettype wire

[design/slid_cell.sv]
// ----------------------------------------------------------------------------
// slid_cell
// one slot of the sorted chain: holds a value, compares it with the key and
// takes a neighbor's value on insert, delete and readout rotation
// ----------------------------------------------------------------------------
`default_nettype none

module slid_cell (
    input  wire logic                              i_clk,
    input  wire slid_pkg::t_cell_op                i_op,
    input  wire slid_pkg::t_cell_pos               i_pos,
    input  wire logic signed [slid_pkg::VAL_W-1:0] i_key,
    input  wire logic signed [slid_pkg::VAL_W-1:0] i_left_val,
    input  wire logic                              i_left_gt,
    input  wire logic signed [slid_pkg::VAL_W-1:0] i_right_val,
    input  wire logic signed [slid_pkg::VAL_W-1:0] i_head_val,
    output logic signed [slid_pkg::VAL_W-1:0]      o_val,
    output logic                                   o_gt,
    output logic                                   o_eq
);

    logic signed [slid_pkg::VAL_W-1:0] r_val;
    logic signed [slid_pkg::VAL_W-1:0] n_val;
    logic                              ge;

    assign o_val = r_val;
    assign o_gt  = i_pos.occ && (r_val > i_key);
    assign ge    = i_pos.occ && (r_val >= i_key);
    assign o_eq  = i_pos.occ && (r_val == i_key);

    always_comb begin
        n_val = r_val;
        case (i_op)
            slid_pkg::CELL_INS: begin
                // left neighbor larger: shift right; first larger or first free: take key
                if (i_left_gt) begin
                    n_val = i_left_val;
                end else if (o_gt || i_pos.at_count) begin
                    n_val = i_key;
                end
            end
            slid_pkg::CELL_DEL: begin
                // first cell at or above the key holds a match; close the gap
                if (ge) begin
                    n_val = i_right_val;
                end
            end
            slid_pkg::CELL_ROTL: begin
                n_val = i_pos.at_tail ? i_head_val : i_right_val;
            end
            slid_pkg::CELL_ROTR: begin
                n_val = i_left_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

[design/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// bounded sorted multiset of signed values built as a chain of compare cells
// ----------------------------------------------------------------------------
// On an insert or delete request every cell compares its value with the
// request value at once and shifts toward or away from its neighbor, so
// one beat enters per cycle while results are taken. A readout of n
// entries yields n result beats (one beat for an empty store); the chain
// rotates one slot per beat and is back in place after the run, and no new
// request is taken until the run's last beat is loaded. The single output
// register lets the next request enter in the cycle its waiting result is
// taken; while a result is stalled the input stalls as well.
`default_nettype none

module sorted_list_insert_delete #(
    parameter int CAPACITY = slid_pkg::CAPACITY
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire slid_pkg::t_in_beat   i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output slid_pkg::t_out_beat       o_out_beat
);

`include "sorted_list_insert_delete_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state              r_state,     n_state;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [CNT_W-1:0]    r_rd_left,   n_rd_left;
    logic                r_desc,      n_desc;
    logic                r_out_valid, n_out_valid;
    slid_pkg::t_out_beat r_out,       n_out;

    slid_pkg::t_cell_op  cell_op;
    slid_pkg::t_cell_pos cell_pos [CAPACITY];
    logic signed [slid_pkg::VAL_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_eq;

    logic signed [slid_pkg::VAL_W-1:0] head_val;
    logic signed [slid_pkg::VAL_W-1:0] tail_val;
    logic signed [slid_pkg::VAL_W-1:0] rd_val;

    logic out_free;
    logic in_ready;
    logic in_acc;
    logic ins_ok;
    logic read_step;
    logic is_empty;
    logic is_full;
    logic found;
    logic use_desc;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc    = i_in_valid && in_ready;
    assign ins_ok    = in_acc && (i_in_beat.kind == slid_pkg::KIND_INSERT) && !is_full;
    assign read_step = (r_state == ST_READ) && out_free;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= CNT_W'(CAPACITY));
    assign found     = |cell_eq;

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // ---- cell chain ----
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [slid_pkg::VAL_W-1:0] left_val;
            logic signed [slid_pkg::VAL_W-1:0] right_val;
            logic                              left_gt;

            assign cell_pos[g].occ      = (r_count > CNT_W'(g));
            assign cell_pos[g].at_tail  = (r_count == CNT_W'(g + 1));
            assign cell_pos[g].at_count = (r_count == CNT_W'(g));

            if (g == 0) begin : g_first
                // right rotation wraps the tail into the head slot
                assign left_val = tail_val;
                assign left_gt  = 1'b0;
            end else begin : g_mid
                assign left_val = cell_val[g-1];
                assign left_gt  = cell_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign right_val = head_val;
            end else begin : g_inner
                assign right_val = cell_val[g+1];
            end

            slid_cell u_cell (
                .i_clk       (i_clk),
                .i_op        (cell_op),
                .i_pos       (cell_pos[g]),
                .i_key       (i_in_beat.value),
                .i_left_val  (left_val),
                .i_left_gt   (left_gt),
                .i_right_val (right_val),
                .i_head_val  (head_val),
                .o_val       (cell_val[g]),
                .o_gt        (cell_gt[g]),
                .o_eq        (cell_eq[g])
            );
        end
    endgenerate

    assign head_val = cell_val[0];

    // and-or pick of the occupied tail slot
    always_comb begin
        tail_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (cell_pos[k].at_tail) begin
                tail_val = tail_val | cell_val[k];
            end
        end
    end

    assign use_desc = in_acc ? (i_in_beat.kind == slid_pkg::KIND_READ_DESC) : r_desc;
    assign rd_val   = use_desc ? tail_val : head_val;

    // ---- control ----
    always_comb begin
        cell_op     = slid_pkg::CELL_HOLD;
        n_state     = r_state;
        n_count     = r_count;
        n_rd_left   = r_rd_left;
        n_desc      = r_desc;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (in_acc) begin
            n_out_valid     = 1'b1;
            n_out.value_out = i_in_beat.value;
            n_out.last      = 1'b1;
            n_out.status    = slid_pkg::STATUS_OK;
            n_out.fill      = slid_pkg::t_fill'(r_count);
            case (i_in_beat.kind)
                slid_pkg::KIND_INSERT: begin
                    if (is_full) begin
                        n_out.status = slid_pkg::STATUS_FULL;
                    end else begin
                        cell_op    = slid_pkg::CELL_INS;
                        n_count    = r_count + CNT_W'(1);
                        n_out.fill = slid_pkg::t_fill'(n_count);
                    end
                end
                slid_pkg::KIND_DELETE: begin
                    if (is_empty) begin
                        n_out.status = slid_pkg::STATUS_EMPTY;
                    end else if (!found) begin
                        n_out.status = slid_pkg::STATUS_NOT_FOUND;
                    end else begin
                        cell_op    = slid_pkg::CELL_DEL;
                        n_count    = r_count - CNT_W'(1);
                        n_out.fill = slid_pkg::t_fill'(n_count);
                    end
                end
                default: begin
                    if (is_empty) begin
                        n_out.status = slid_pkg::STATUS_EMPTY;
                    end else begin
                        n_desc          = use_desc;
                        cell_op         = use_desc ? slid_pkg::CELL_ROTR : slid_pkg::CELL_ROTL;
                        n_out.value_out = rd_val;
                        n_out.last      = (r_count == CNT_W'(1));
                        n_rd_left       = r_count - CNT_W'(1);
                        if (r_count != CNT_W'(1)) begin
                            n_state = ST_READ;
                        end
                    end
                end
            endcase
        end else if (read_step) begin
            cell_op         = r_desc ? slid_pkg::CELL_ROTR : slid_pkg::CELL_ROTL;
            n_out_valid     = 1'b1;
            n_out.status    = slid_pkg::STATUS_OK;
            n_out.value_out = rd_val;
            n_out.last      = (r_rd_left == CNT_W'(1));
            n_out.fill      = slid_pkg::t_fill'(r_count);
            n_rd_left       = r_rd_left - CNT_W'(1);
            if (r_rd_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_left   <= '0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_left   <= n_rd_left;
            r_desc      <= n_desc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ---- checks ----
    `SLID_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SLID_ASSERT_NOW(a_no_accept_in_run, r_state == ST_READ, o_in_stall)
    `SLID_ASSERT_NEXT(a_insert_grows, ins_ok, r_count == $past(r_count) + CNT_W'(1))
    `SLID_ASSERT_NEXT(a_run_ends_last, read_step && (r_rd_left == CNT_W'(1)), o_out_valid && o_out_beat.last && (r_state == ST_IDLE))

endmodule

`default_nettype wire
